>>> rtl/vrdpm_pkg.sv
package vrdpm_pkg;

  localparam int unsigned PAGE_COUNT = 512;
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT);
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORD_SH    = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = $clog2(MAP_WORDS);
  localparam int unsigned BLK_SH     = 5;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned PER_ROW_W  = 6;
  localparam int unsigned PROD_W     = ROW_W + PER_ROW_W;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic       known;
    logic       wide;
    logic [2:0] th_sh;
  } fmt_info_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic setup;
    logic walk;
    logic flush;
    logic fill;
    logic clear;
    logic rd_sel;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    empty;
    logic    known;
    logic    walk_last;
    logic    fill_last;
  } dp_stat_t;

  function automatic fmt_info_t decode_fmt(input logic [5:0] fmt);
    fmt_info_t info;
    info.known = 1'b1;
    info.wide  = 1'b0;
    info.th_sh = 3'd5;
    unique case (fmt)
      6'h00, 6'h01, 6'h1B, 6'h24, 6'h2C, 6'h30, 6'h31: begin
        info.th_sh = 3'd5;
      end
      6'h02, 6'h0A, 6'h32, 6'h3A: begin
        info.th_sh = 3'd6;
      end
      6'h13: begin
        info.wide  = 1'b1;
        info.th_sh = 3'd6;
      end
      6'h14: begin
        info.wide  = 1'b1;
        info.th_sh = 3'd7;
      end
      default: begin
        info.known = 1'b0;
      end
    endcase
    return info;
  endfunction

endpackage

>>> rtl/vrdpm_ctrl.sv
module vrdpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vrdpm_pkg::dp_stat_t stat_i,
  output vrdpm_pkg::dp_cmd_t  cmd_o
);
  import vrdpm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_WALK   = 7'b0001000,
    ST_FLUSH  = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_READ   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_MARK: begin
            priority if (stat_i.empty) begin
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end else if (!stat_i.known) begin
              state_d = ST_FILL;
            end else begin
              cmd_o.decode = 1'b1;
              state_d      = ST_SETUP;
            end
          end
          OP_READ: begin
            cmd_o.rd_sel = 1'b1;
            state_d      = ST_READ;
          end
          OP_CLEAR: begin
            cmd_o.clear  = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
          OP_NOP: begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        endcase
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/vrdpm_dp.sv
module vrdpm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrdpm_pkg::dp_cmd_t  cmd_i,
  output vrdpm_pkg::dp_stat_t stat_o,
  input  logic [1:0]          opcode_i,
  input  logic [13:0]         base_block_i,
  input  logic [5:0]          buffer_width_i,
  input  logic [5:0]          pixel_format_i,
  input  logic [11:0]         rect_width_i,
  input  logic [11:0]         rect_height_i,
  input  logic [10:0]         origin_x_i,
  input  logic [10:0]         origin_y_i,
  input  logic [2:0]          word_select_i,
  output logic                done_o,
  output logic [63:0]         map_word_o,
  output logic                unknown_format_o
);
  import vrdpm_pkg::*;

  opcode_e     op_q;
  logic [13:0] base_q;
  logic [5:0]  bw_q;
  logic [5:0]  fmt_q;
  logic [11:0] w_q;
  logic [11:0] h_q;
  logic [10:0] x_q;
  logic [10:0] y_q;
  logic [2:0]  sel_q;

  fmt_info_t          info;
  logic               empty;
  logic [12:0]        x_end;
  logic [12:0]        y_end;
  logic [COL_W-1:0]   first_col_c, last_col_c;
  logic [ROW_W-1:0]   first_row_c, last_row_c;
  logic [5:0]         bw_eff;
  logic [PER_ROW_W-1:0] per_row_raw, per_row_c;

  logic [COL_W-1:0]     first_col_q, last_col_q;
  logic [ROW_W-1:0]     first_row_q, last_row_q;
  logic [PER_ROW_W-1:0] per_row_q;
  logic [PAGE_W-1:0]    base_page_q;
  logic                 unaligned_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              sub_q, sub_d;
  logic [PAGE_W-1:0] rbase_q, rbase_d;
  logic [PROD_W-1:0] row_off_c;

  logic [PAGE_W-1:0]    page_c;
  logic [WIDX_W-1:0]    widx_c;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 at_end, hit, adv, miss;

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_ok_q;
  logic                 rd_range_q;
  logic                 mem_we, mem_re;
  logic [WIDX_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [WORD_BITS-1:0] cur_word_q, cur_word_d;
  logic [WIDX_W-1:0]    cur_idx_q, cur_idx_d;
  logic                 cur_live_q, cur_live_d;
  logic                 fetch_q, fetch_d;
  logic [WIDX_W-1:0]    fill_q;

  logic                 done_q;
  logic [WORD_BITS-1:0] map_word_q;
  logic                 unknown_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_e'(opcode_i);
      base_q <= base_block_i;
      bw_q   <= buffer_width_i;
      fmt_q  <= pixel_format_i;
      w_q    <= rect_width_i;
      h_q    <= rect_height_i;
      x_q    <= origin_x_i;
      y_q    <= origin_y_i;
      sel_q  <= word_select_i;
    end
  end

  assign info  = decode_fmt(fmt_q);
  assign empty = (w_q == 12'd0) || (h_q == 12'd0);
  assign x_end = 13'(x_q) + 13'(w_q) - 13'd1;
  assign y_end = 13'(y_q) + 13'(h_q) - 13'd1;

  always_comb begin
    if (info.wide) begin
      first_col_c = COL_W'(x_q >> 7);
      last_col_c  = COL_W'(x_end >> 7);
    end else begin
      first_col_c = COL_W'(x_q >> 6);
      last_col_c  = COL_W'(x_end >> 6);
    end
    unique case (info.th_sh)
      3'd5: begin
        first_row_c = ROW_W'(y_q >> 5);
        last_row_c  = ROW_W'(y_end >> 5);
      end
      3'd6: begin
        first_row_c = ROW_W'(y_q >> 6);
        last_row_c  = ROW_W'(y_end >> 6);
      end
      default: begin
        first_row_c = ROW_W'(y_q >> 7);
        last_row_c  = ROW_W'(y_end >> 7);
      end
    endcase
  end

  assign bw_eff      = (bw_q == 6'd0) ? 6'd1 : bw_q;
  assign per_row_raw = info.wide ? PER_ROW_W'(bw_eff >> 1) : PER_ROW_W'(bw_eff);
  assign per_row_c   = (per_row_raw == '0) ? PER_ROW_W'(1) : per_row_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      first_col_q <= first_col_c;
      last_col_q  <= last_col_c;
      first_row_q <= first_row_c;
      last_row_q  <= last_row_c;
      per_row_q   <= per_row_c;
      base_page_q <= PAGE_W'(base_q >> BLK_SH);
      unaligned_q <= (base_q[BLK_SH-1:0] != '0);
    end
  end

  assign row_off_c = PROD_W'(first_row_q) * PROD_W'(per_row_q);
  assign page_c    = PAGE_W'(rbase_q + PAGE_W'(col_q) + PAGE_W'(sub_q));
  assign widx_c    = page_c[PAGE_W-1:WORD_SH];
  assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << page_c[WORD_SH-1:0];
  assign at_end    = (col_q == last_col_q) && (row_q == last_row_q) && (sub_q || !unaligned_q);
  assign hit       = cur_live_q && (cur_idx_q == widx_c);
  assign adv       = cmd_i.walk && (fetch_q || hit);
  assign miss      = cmd_i.walk && !fetch_q && !hit;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    sub_d   = sub_q;
    rbase_d = rbase_q;
    if (cmd_i.setup) begin
      row_d   = first_row_q;
      col_d   = first_col_q;
      sub_d   = 1'b0;
      rbase_d = PAGE_W'(row_off_c) + base_page_q;
    end else if (adv) begin
      if (unaligned_q && !sub_q) begin
        sub_d = 1'b1;
      end else begin
        sub_d = 1'b0;
        if (col_q == last_col_q) begin
          col_d   = first_col_q;
          row_d   = row_q + ROW_W'(1);
          rbase_d = rbase_q + PAGE_W'(per_row_q);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      sub_q   <= 1'b0;
      rbase_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      sub_q   <= sub_d;
      rbase_q <= rbase_d;
    end
  end

  always_comb begin
    cur_word_d = cur_word_q;
    cur_idx_d  = cur_idx_q;
    cur_live_d = cur_live_q;
    fetch_d    = fetch_q;
    if (cmd_i.walk) begin
      priority if (fetch_q) begin
        cur_word_d = (rd_ok_q ? rd_data_q : '0) | bit_mask;
        cur_live_d = 1'b1;
        fetch_d    = 1'b0;
      end else if (hit) begin
        cur_word_d = cur_word_q | bit_mask;
      end else begin
        cur_idx_d  = widx_c;
        cur_live_d = 1'b0;
        fetch_d    = 1'b1;
      end
    end
    if (cmd_i.flush) begin
      cur_live_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_word_q <= cur_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q  <= '0;
      cur_live_q <= 1'b0;
      fetch_q    <= 1'b0;
    end else begin
      cur_idx_q  <= cur_idx_d;
      cur_live_q <= cur_live_d;
      fetch_q    <= fetch_d;
    end
  end

  assign mem_we    = ((miss || cmd_i.flush) && cur_live_q) || cmd_i.fill;
  assign mem_waddr = cmd_i.fill ? fill_q : cur_idx_q;
  assign mem_wdata = cmd_i.fill ? '1 : cur_word_q;
  assign mem_re    = miss || cmd_i.rd_sel;
  assign mem_raddr = cmd_i.rd_sel ? WIDX_W'(sel_q) : widx_c;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_ok_q    <= 1'b0;
      rd_range_q <= 1'b0;
      fill_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_ok_q <= valid_q[mem_raddr];
      end
      if (cmd_i.rd_sel) begin
        rd_range_q <= (32'(sel_q) < MAP_WORDS);
      end
      if (cmd_i.load) begin
        fill_q <= '0;
      end else if (cmd_i.fill) begin
        fill_q <= fill_q + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      map_word_q <= (op_q == OP_READ && rd_range_q && rd_ok_q) ? rd_data_q : '0;
      unknown_q  <= (op_q == OP_MARK) && !empty && !info.known;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = empty;
  assign stat_o.known     = info.known;
  assign stat_o.walk_last = adv && at_end;
  assign stat_o.fill_last = (fill_q == WIDX_W'(MAP_WORDS - 1));

  assign done_o           = done_q;
  assign map_word_o       = map_word_q;
  assign unknown_format_o = unknown_q;

endmodule

>>> rtl/vram_rect_dirty_page_marker_top.sv
// Channel   Handshake          Payload
// request   start / busy       opcode_i, base_block_i, buffer_width_i, pixel_format_i,
//                              rect_width_i, rect_height_i, origin_x_i, origin_y_i,
//                              word_select_i
// result    done_o (1 cycle)   map_word_o, unknown_format_o
//
// A request is taken when start is high and busy is low; its result strobes on done_o.
// Mark: sets P pages, one per cycle except while a map word is fetched (two pages
// per tile on an unaligned base), and fetches F 64-bit map words from the map RAM.
// Unknown format: the whole map is filled, one map word filled per cycle.
// Reset clears the map at once through per-word valid bits; no clearing pass.
// The receiver cannot stall; busy is low during the result cycle.
module vram_rect_dirty_page_marker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [13:0] base_block_i,
  input  logic [5:0]  buffer_width_i,
  input  logic [5:0]  pixel_format_i,
  input  logic [11:0] rect_width_i,
  input  logic [11:0] rect_height_i,
  input  logic [10:0] origin_x_i,
  input  logic [10:0] origin_y_i,
  input  logic [2:0]  word_select_i,
  output logic        done_o,
  output logic [63:0] map_word_o,
  output logic        unknown_format_o
);
  import vrdpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vrdpm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  vrdpm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (opcode_i),
    .base_block_i     (base_block_i),
    .buffer_width_i   (buffer_width_i),
    .pixel_format_i   (pixel_format_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .word_select_i    (word_select_i),
    .done_o           (done_o),
    .map_word_o       (map_word_o),
    .unknown_format_o (unknown_format_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while a request is in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unknown_format_o) |-> (map_word_o == '0))
    else $error("unknown-format mark returned map data");
`endif

endmodule
